### rtl/acmc_pkg.sv
// types, codes and helper functions of the alarm clock mode controller
package acmc_pkg;

  localparam int unsigned DelayWidth  = 10;
  localparam int unsigned PeriodWidth = 8;
  localparam int unsigned HoursWidth  = 6;
  localparam int unsigned MinWidth    = 7;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDatWidth = 10;

  localparam logic [DelayWidth-1:0]  DELAY_RESET  = 10'd100;
  localparam logic [PeriodWidth-1:0] PERIOD_RESET = 8'd10;

  localparam logic [MinWidth-1:0] HOURS_MAX   = 7'h23;
  localparam logic [MinWidth-1:0] MINUTES_MAX = 7'h59;

  // button press classes
  localparam logic [1:0] PRESS_IDLE  = 2'd0;
  localparam logic [1:0] PRESS_SHORT = 2'd1;
  localparam logic [1:0] PRESS_LONG  = 2'd2;

  // mode codes as seen on the result channel
  localparam logic [1:0] CODE_IDLE      = 2'd0;
  localparam logic [1:0] CODE_RING      = 2'd1;
  localparam logic [1:0] CODE_SET_TIME  = 2'd2;
  localparam logic [1:0] CODE_SET_ALARM = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_REPEAT_DELAY  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_REPEAT_PERIOD = 2'd1;

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_RING      = 4'b0010,
    MODE_SET_TIME  = 4'b0100,
    MODE_SET_ALARM = 4'b1000
  } mode_state_t;

  typedef struct packed {
    logic                   armed;
    logic [DelayWidth-1:0]  delay;
    logic [PeriodWidth-1:0] period;
  } repeat_t;

  typedef struct packed {
    repeat_t st;
    logic    fire;
  } repeat_res_t;

  function automatic logic [1:0] mode_code(input mode_state_t m);
    logic [1:0] c;
    case (m)
      MODE_IDLE:      c = CODE_IDLE;
      MODE_RING:      c = CODE_RING;
      MODE_SET_TIME:  c = CODE_SET_TIME;
      MODE_SET_ALARM: c = CODE_SET_ALARM;
      default:        c = CODE_IDLE;
    endcase
    return c;
  endfunction

  // bcd increment with wrap at max, done at minutes width
  function automatic logic [MinWidth-1:0] bcd_inc(input logic [MinWidth-1:0] v,
                                                  input logic [MinWidth-1:0] max);
    logic [MinWidth-1:0] r;
    if (v >= max) begin
      r = '0;
    end else if (v[3:0] >= 4'd9) begin
      r = {v[MinWidth-1:4] + 3'd1, 4'd0};
    end else begin
      r = v + 7'd1;
    end
    return r;
  endfunction

  function automatic repeat_res_t repeat_step(input repeat_t r,
                                              input logic [1:0] cur,
                                              input logic [1:0] prev,
                                              input logic [DelayWidth-1:0] dly,
                                              input logic [PeriodWidth-1:0] per);
    repeat_res_t      res;
    logic [PeriodWidth:0] p;
    res.st   = r;
    res.fire = 1'b0;
    p        = {1'b0, r.period} + 9'd1;
    if (cur == PRESS_LONG && prev != PRESS_LONG) begin
      res.st.armed = 1'b1;
    end else if (cur == PRESS_LONG && prev == PRESS_LONG && r.armed) begin
      if (r.delay < dly) begin
        res.st.delay = r.delay + 10'd1;
      end else if (p >= {1'b0, per}) begin
        res.st.period = '0;
        res.fire      = 1'b1;
      end else begin
        res.st.period = p[PeriodWidth-1:0];
      end
    end else if (cur == PRESS_IDLE) begin
      res.st = '0;
    end
    return res;
  endfunction

endpackage

### rtl/alarm_clock_mode_controller.sv
// alarm clock mode controller: mode machine, bcd editing and auto-repeat
//
// One input request is one handler tick: both button classes, the rtc time
// in bcd, the alarm pulse and the led dim status. Each tick gives exactly
// one result: the mode after the tick, the shown time and the time and alarm
// write, blink and screen-clear strobes.
// A request is taken when in_valid is high and in_stall is low; a result
// leaves when out_valid is high and out_stall is low.
// An accepted tick lands in the input register; the mode logic then reads
// it combinationally and fills the result register. One tick per cycle is
// sustained while the receiver does not stall; the mode and repeat
// registers update once per tick that leaves the input register.
// When the receiver stalls the result register holds, the input register
// fills behind it and in_stall rises only when both are occupied.
// The configuration port is always ready; index 0 is the repeat delay,
// index 1 the repeat period, other indexes are ignored. Write it only
// while no tick is in flight.
// Reset (rst_n low, synchronous) empties both registers, returns to idle
// mode with all edit and repeat state cleared and restores the default
// delay of 100 and period of 10 ticks.
module alarm_clock_mode_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_button0_press,
  input  logic [1:0]                        in_button1_press,
  input  logic                              in_alarm_event,
  input  logic                              in_led_dim,
  input  logic [acmc_pkg::HoursWidth-1:0]   in_rtc_hours,
  input  logic [acmc_pkg::MinWidth-1:0]     in_rtc_minutes,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_mode,
  output logic [acmc_pkg::HoursWidth-1:0]   out_shown_hours,
  output logic [acmc_pkg::MinWidth-1:0]     out_shown_minutes,
  output logic                              out_write_time,
  output logic                              out_write_alarm,
  output logic                              out_blink_start,
  output logic                              out_blink_stop,
  output logic                              out_clear_screen,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [acmc_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [acmc_pkg::CfgDatWidth-1:0]  cfg_data
);
  import acmc_pkg::*;

  // configuration
  logic [DelayWidth-1:0]  delay_cfg_r;
  logic [PeriodWidth-1:0] period_cfg_r;

  // input register
  logic                  s1_valid_r;
  logic [1:0]            s1_b0_r, s1_b1_r;
  logic                  s1_ev_r, s1_dim_r;
  logic [HoursWidth-1:0] s1_rh_r;
  logic [MinWidth-1:0]   s1_rm_r;

  // block state
  mode_state_t           mode_r, mode_nxt;
  logic [1:0]            prev0_r, prev1_r;
  logic                  pend_r, pend_nxt;
  logic                  ring_r, ring_nxt;
  logic                  loaded_r, loaded_nxt;
  logic [HoursWidth-1:0] edit_h_r, edit_h_nxt, alarm_h_r, alarm_h_nxt;
  logic [MinWidth-1:0]   edit_m_r, edit_m_nxt, alarm_m_r, alarm_m_nxt;
  repeat_t               rep_h_r, rep_h_nxt, rep_m_r, rep_m_nxt;

  // result values
  logic [HoursWidth-1:0] sh_nxt;
  logic [MinWidth-1:0]   sm_nxt;
  logic                  wt_nxt, wa_nxt, bs_nxt, bp_nxt;

  logic                  advance;
  logic                  new0, new1;
  logic                  is_time;
  logic [HoursWidth-1:0] cur_h, new_h;
  logic [MinWidth-1:0]   cur_m, new_m;
  repeat_res_t           rh_res, rm_res;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall  = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_cfg_r  <= DELAY_RESET;
      period_cfg_r <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REPEAT_DELAY:  delay_cfg_r  <= cfg_data;
        CFG_REPEAT_PERIOD: period_cfg_r <= cfg_data[PeriodWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_b0_r  <= in_button0_press;
      s1_b1_r  <= in_button1_press;
      s1_ev_r  <= in_alarm_event;
      s1_dim_r <= in_led_dim;
      s1_rh_r  <= in_rtc_hours;
      s1_rm_r  <= in_rtc_minutes;
    end
  end

  assign new0    = (s1_b0_r == PRESS_LONG) && (prev0_r != PRESS_LONG);
  assign new1    = (s1_b1_r == PRESS_LONG) && (prev1_r != PRESS_LONG);
  assign is_time = (mode_r == MODE_SET_TIME);

  // value being edited; set time picks up the rtc time on entry
  always_comb begin
    if (is_time) begin
      cur_h = loaded_r ? edit_h_r : s1_rh_r;
      cur_m = loaded_r ? edit_m_r : s1_rm_r;
    end else begin
      cur_h = alarm_h_r;
      cur_m = alarm_m_r;
    end
  end

  assign rh_res = repeat_step(rep_h_r, s1_b0_r, prev0_r, delay_cfg_r, period_cfg_r);
  assign rm_res = repeat_step(rep_m_r, s1_b1_r, prev1_r, delay_cfg_r, period_cfg_r);

  // a short press and a repeat fire never coincide, so one increment at most
  always_comb begin
    logic [MinWidth-1:0] h_inc;
    h_inc = bcd_inc({1'b0, cur_h}, HOURS_MAX);
    new_h = (s1_b0_r == PRESS_SHORT || rh_res.fire) ? h_inc[HoursWidth-1:0] : cur_h;
    new_m = (s1_b1_r == PRESS_SHORT || rm_res.fire) ? bcd_inc(cur_m, MINUTES_MAX) : cur_m;
  end

  always_comb begin
    logic wrote;
    wrote       = 1'b0;
    mode_nxt    = mode_r;
    pend_nxt    = pend_r | s1_ev_r;
    ring_nxt    = ring_r;
    loaded_nxt  = loaded_r;
    edit_h_nxt  = edit_h_r;
    edit_m_nxt  = edit_m_r;
    alarm_h_nxt = alarm_h_r;
    alarm_m_nxt = alarm_m_r;
    rep_h_nxt   = rep_h_r;
    rep_m_nxt   = rep_m_r;
    wt_nxt      = 1'b0;
    wa_nxt      = 1'b0;
    bs_nxt      = 1'b0;
    bp_nxt      = 1'b0;
    case (mode_r)
      MODE_IDLE: begin
        if (pend_nxt) begin
          pend_nxt = 1'b0;
          mode_nxt = MODE_RING;
        end else if (new0 && s1_b1_r != PRESS_LONG) begin
          mode_nxt = MODE_SET_TIME;
        end else if (new1) begin
          mode_nxt = MODE_SET_ALARM;
        end
      end
      MODE_RING: begin
        bs_nxt   = !ring_r;
        ring_nxt = 1'b1;
        if (s1_b0_r == PRESS_SHORT || s1_b1_r == PRESS_SHORT || new0 || new1) begin
          mode_nxt = MODE_IDLE;
          ring_nxt = 1'b0;
          bp_nxt   = 1'b1;
        end else if (s1_dim_r && ring_r) begin
          // dim is stale on the tick that starts the blink
          mode_nxt = MODE_IDLE;
          ring_nxt = 1'b0;
        end
      end
      MODE_SET_TIME, MODE_SET_ALARM: begin
        if (s1_b0_r == PRESS_LONG && s1_b1_r == PRESS_LONG) begin
          wrote     = 1'b1;
          mode_nxt  = MODE_IDLE;
          rep_h_nxt = '0;
          rep_m_nxt = '0;
          if (is_time) begin
            wt_nxt     = 1'b1;
            loaded_nxt = 1'b0;
            edit_h_nxt = cur_h;
            edit_m_nxt = cur_m;
          end else begin
            wa_nxt = 1'b1;
          end
        end else begin
          rep_h_nxt = rh_res.st;
          rep_m_nxt = rm_res.st;
          if (is_time) begin
            loaded_nxt = 1'b1;
            edit_h_nxt = new_h;
            edit_m_nxt = new_m;
          end else begin
            alarm_h_nxt = new_h;
            alarm_m_nxt = new_m;
          end
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    if (wrote) begin
      sh_nxt = cur_h;
      sm_nxt = cur_m;
    end else if (mode_nxt == MODE_SET_TIME && loaded_nxt) begin
      sh_nxt = edit_h_nxt;
      sm_nxt = edit_m_nxt;
    end else if (mode_nxt == MODE_SET_ALARM) begin
      sh_nxt = alarm_h_nxt;
      sm_nxt = alarm_m_nxt;
    end else begin
      sh_nxt = s1_rh_r;
      sm_nxt = s1_rm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      prev0_r   <= PRESS_IDLE;
      prev1_r   <= PRESS_IDLE;
      pend_r    <= 1'b0;
      ring_r    <= 1'b0;
      loaded_r  <= 1'b0;
      edit_h_r  <= '0;
      edit_m_r  <= '0;
      alarm_h_r <= '0;
      alarm_m_r <= '0;
      rep_h_r   <= '0;
      rep_m_r   <= '0;
    end else if (advance) begin
      mode_r    <= mode_nxt;
      prev0_r   <= s1_b0_r;
      prev1_r   <= s1_b1_r;
      pend_r    <= pend_nxt;
      ring_r    <= ring_nxt;
      loaded_r  <= loaded_nxt;
      edit_h_r  <= edit_h_nxt;
      edit_m_r  <= edit_m_nxt;
      alarm_h_r <= alarm_h_nxt;
      alarm_m_r <= alarm_m_nxt;
      rep_h_r   <= rep_h_nxt;
      rep_m_r   <= rep_m_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode          <= mode_code(mode_nxt);
      out_shown_hours   <= sh_nxt;
      out_shown_minutes <= sm_nxt;
      out_write_time    <= wt_nxt;
      out_write_alarm   <= wa_nxt;
      out_blink_start   <= bs_nxt;
      out_blink_stop    <= bp_nxt;
      out_clear_screen  <= (mode_nxt != mode_r);
    end
  end

endmodule
